/* rtl/core/eprf_pkg.sv */
// shared constants, types and codes for the ecg peak rate framer
`default_nettype none

package eprf_pkg;

    // field and register widths
    localparam int SAMPLE_BITS_DEF = 14;
    localparam int WIDE_W          = 16;
    localparam int THRESH_W        = 14;
    localparam int NUM_W           = 16;
    localparam int LEN_W           = 10;
    localparam int CFG_W           = 16;
    localparam int IDX_W           = 2;
    localparam int PEAKS_W         = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_RATE_NUMERATOR = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd2;

    // register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd7000;
    localparam logic [NUM_W-1:0]    NUM_RESET    = 16'd12000;
    localparam logic [LEN_W-1:0]    LEN_RESET    = 10'd400;
    localparam logic [LEN_W-1:0]    MIN_WINDOW   = 10'd3;

    // frame bytes
    localparam logic [7:0] SYNC_BYTE     = 8'h5A;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;
    localparam logic [7:0] LOW_ZERO_CODE = 8'h01;
    localparam logic [7:0] RATE_MAX      = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYNC,
        ST_HIGH,
        ST_LOW,
        ST_TSYNC,
        ST_TZERO,
        ST_TRATE
    } state_t;

    typedef enum logic [2:0] {
        SEL_SYNC,
        SEL_HIGH,
        SEL_LOW,
        SEL_ZERO,
        SEL_RATE
    } byte_sel_t;

    typedef struct packed {
        logic      load;
        byte_sel_t sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic trailer;
        logic div_busy;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/eprf_div.sv */
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module eprf_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [eprf_pkg::NUM_W-1:0]  numerator,
    input  wire logic [eprf_pkg::LEN_W-1:0]  divisor,
    output logic                             busy,
    output logic [eprf_pkg::NUM_W-1:0]       quotient
);

    localparam int NW    = eprf_pkg::NUM_W;
    localparam int DW    = eprf_pkg::LEN_W;
    localparam int CNT_W = $clog2(NW);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DW:0]      trial;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
        quo_next = {quo_reg[NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= numerator;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/eprf_datapath.sv */
// config registers, peak tracking, frame byte select and rate divider
`default_nettype none

module eprf_datapath #(
    parameter int SAMPLE_BITS = eprf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [eprf_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [eprf_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]      sample,
    input  wire logic                        stop_request,
    input  wire eprf_pkg::ctrl_cmd_t         cmd,
    output eprf_pkg::dp_status_t             status,
    output logic [7:0]                       out_byte
);

    localparam int WW = eprf_pkg::WIDE_W;
    localparam int LW = eprf_pkg::LEN_W;
    localparam int PW = eprf_pkg::PEAKS_W;

    logic [eprf_pkg::THRESH_W-1:0] thr_reg;
    logic [eprf_pkg::NUM_W-1:0]    num_reg;
    logic [LW-1:0]                 wlen_reg;

    logic [SAMPLE_BITS-1:0] prev_reg, cand_reg;
    logic [LW-1:0]          pos_reg, first_reg, second_reg;
    logic [PW-1:0]          peaks_reg;
    logic [7:0]             hi_reg, lo_reg;
    logic                   trailer_reg, rate_ok_reg;

    logic [WW-1:0]          s_w, cand_w, prev_w, thr_w;
    logic                   peak;
    logic [PW-1:0]          peaks_next;
    logic [LW-1:0]          first_next, second_next, len_eff, peak_gap;
    logic                   eow, rate_ok, div_start, div_busy;
    logic [7:0]             lo_code, rate_byte;
    logic [eprf_pkg::NUM_W-1:0] quotient;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= eprf_pkg::THRESH_RESET;
            num_reg  <= eprf_pkg::NUM_RESET;
            wlen_reg <= eprf_pkg::LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                eprf_pkg::REG_PEAK_THRESHOLD: thr_reg  <= cfg_data[eprf_pkg::THRESH_W-1:0];
                eprf_pkg::REG_RATE_NUMERATOR: num_reg  <= cfg_data[eprf_pkg::NUM_W-1:0];
                eprf_pkg::REG_WINDOW_LENGTH:  wlen_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // candidate is judged once its right neighbour arrives
    always_comb
    begin
        s_w    = WW'(sample);
        cand_w = WW'(cand_reg);
        prev_w = WW'(prev_reg);
        thr_w  = WW'(thr_reg);
        peak   = (pos_reg >= LW'(2)) && (cand_w >= thr_w) &&
                 (cand_w > prev_w) && (cand_w > s_w);

        peaks_next  = peaks_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (peak)
        begin
            unique case (peaks_reg)
                PW'(0):
                begin
                    first_next = pos_reg - 1'b1;
                    peaks_next = PW'(1);
                end
                PW'(1):
                begin
                    second_next = pos_reg - 1'b1;
                    peaks_next  = PW'(2);
                end
                default: ;
            endcase
        end

        len_eff   = (wlen_reg < eprf_pkg::MIN_WINDOW) ? eprf_pkg::MIN_WINDOW : wlen_reg;
        eow       = pos_reg >= (len_eff - 1'b1);
        peak_gap  = second_next - first_next;
        rate_ok   = (peaks_next == PW'(2)) && (peak_gap != '0);
        div_start = cmd.load && !stop_request && eow && rate_ok;
        lo_code   = (s_w[7:0] == 8'h00) ? eprf_pkg::LOW_ZERO_CODE : s_w[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            cand_reg    <= '0;
            pos_reg     <= '0;
            peaks_reg   <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            trailer_reg <= 1'b0;
            rate_ok_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            prev_reg    <= cand_reg;
            cand_reg    <= sample;
            trailer_reg <= !stop_request && eow;
            rate_ok_reg <= rate_ok;
            if (stop_request || eow)
            begin
                pos_reg    <= '0;
                peaks_reg  <= '0;
                first_reg  <= '0;
                second_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_reg + 1'b1;
                peaks_reg  <= peaks_next;
                first_reg  <= first_next;
                second_reg <= second_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hi_reg <= s_w[15:8];
            lo_reg <= lo_code;
        end
    end

    eprf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (num_reg),
        .divisor   (peak_gap),
        .busy      (div_busy),
        .quotient  (quotient)
    );

    always_comb
    begin
        if (!rate_ok_reg)
        begin
            rate_byte = eprf_pkg::ZERO_BYTE;
        end
        else if (quotient > eprf_pkg::NUM_W'(eprf_pkg::RATE_MAX))
        begin
            rate_byte = eprf_pkg::RATE_MAX;
        end
        else
        begin
            rate_byte = quotient[7:0];
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            eprf_pkg::SEL_SYNC: out_byte = eprf_pkg::SYNC_BYTE;
            eprf_pkg::SEL_HIGH: out_byte = hi_reg;
            eprf_pkg::SEL_LOW:  out_byte = lo_reg;
            eprf_pkg::SEL_RATE: out_byte = rate_byte;
            default:            out_byte = eprf_pkg::ZERO_BYTE;
        endcase
    end

    assign status.trailer  = trailer_reg;
    assign status.div_busy = div_busy;

endmodule

`default_nettype wire

/* rtl/core/eprf_ctrl.sv */
// byte sequencer state machine for sample and trailer frames
`default_nettype none

module eprf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       last_of_run,
    input  wire eprf_pkg::dp_status_t  status,
    output eprf_pkg::ctrl_cmd_t        cmd
);

    eprf_pkg::state_t state_reg, state_next;
    logic             xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eprf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign xfer = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eprf_pkg::ST_IDLE:
                if (in_valid) state_next = eprf_pkg::ST_SYNC;
            eprf_pkg::ST_SYNC:
                if (xfer) state_next = eprf_pkg::ST_HIGH;
            eprf_pkg::ST_HIGH:
                if (xfer) state_next = eprf_pkg::ST_LOW;
            eprf_pkg::ST_LOW:
                if (xfer) state_next = status.trailer ? eprf_pkg::ST_TSYNC
                                                      : eprf_pkg::ST_IDLE;
            eprf_pkg::ST_TSYNC:
                if (xfer) state_next = eprf_pkg::ST_TZERO;
            eprf_pkg::ST_TZERO:
                if (xfer) state_next = eprf_pkg::ST_TRATE;
            eprf_pkg::ST_TRATE:
                if (xfer) state_next = eprf_pkg::ST_IDLE;
            default:
                state_next = eprf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b1;
        last_of_run = 1'b0;
        cmd.load    = 1'b0;
        cmd.sel     = eprf_pkg::SEL_ZERO;
        unique case (state_reg)
            eprf_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                out_valid = 1'b0;
                cmd.load  = in_valid;
            end
            eprf_pkg::ST_SYNC:  cmd.sel = eprf_pkg::SEL_SYNC;
            eprf_pkg::ST_HIGH:  cmd.sel = eprf_pkg::SEL_HIGH;
            eprf_pkg::ST_LOW:
            begin
                cmd.sel     = eprf_pkg::SEL_LOW;
                last_of_run = !status.trailer;
            end
            eprf_pkg::ST_TSYNC: cmd.sel = eprf_pkg::SEL_SYNC;
            eprf_pkg::ST_TZERO: cmd.sel = eprf_pkg::SEL_ZERO;
            eprf_pkg::ST_TRATE:
            begin
                // rate byte waits for the divider
                cmd.sel     = eprf_pkg::SEL_RATE;
                out_valid   = !status.div_busy;
                last_of_run = 1'b1;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/ecg_peak_rate_framer.sv */
// top level of the ecg peak rate framer: sequencer plus datapath
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    sample, stop_request
//  out       source     out_valid / out_ready  out_byte, last_of_run
//  cfg       sink       cfg_write              cfg_index, cfg_data
//
// a sample is taken while the sequencer is idle and its three-byte frame
// follows, one byte per cycle while the sink is ready
// a window-closing sample without stop_request adds a trailer frame whose rate
// byte waits for a 16-step restoring divider started at the sample's transfer,
// unless fewer than two peaks leave the divider idle
// reset returns the sequencer and peak tracking to zero and the config
// registers to their defaults at once
// a stall on the out side freezes the current byte; in_ready is low until
// the last byte of the item is transferred
`default_nettype none

module ecg_peak_rate_framer #(
    parameter int SAMPLE_BITS = eprf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // sample channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [SAMPLE_BITS-1:0]      sample,
    input  wire logic                        stop_request,
    // byte channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_byte,
    output logic                             last_of_run,
    // configuration writes
    input  wire logic                        cfg_write,
    input  wire logic [eprf_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [eprf_pkg::CFG_W-1:0]  cfg_data
);

    eprf_pkg::ctrl_cmd_t  cmd;
    eprf_pkg::dp_status_t status;

    // sequencer: walks the frame bytes and gates the trailer on the divider
    eprf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .last_of_run (last_of_run),
        .status      (status),
        .cmd         (cmd)
    );

    // datapath: registers, peak detection on the sample transfer, byte mux
    eprf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .stop_request (stop_request),
        .cmd          (cmd),
        .status       (status),
        .out_byte     (out_byte)
    );

endmodule

`default_nettype wire

/* rtl/core/eprf_checker.sv */
// port-level checker for the ecg peak rate framer and its bind
`default_nettype none

module eprf_port_checks (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [7:0]                  out_byte,
    input wire logic                        last_of_run
);

    // a stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("stalled byte changed");

    // never accepting a sample while bytes are pending
    a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("in_ready with bytes pending");

    // every frame opens with the sync byte right after the sample transfer
    a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid && out_byte == eprf_pkg::SYNC_BYTE && !in_ready)
        else $error("frame does not open with sync");

    // closing byte of an item frees the input side
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_run |=> in_ready)
        else $error("not ready after last byte");

    // non-final bytes never release the input side
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> !in_ready)
        else $error("released mid item");

endmodule

bind ecg_peak_rate_framer eprf_port_checks u_port_checks (.*);

`default_nettype wire

/* bench/eprf_checker.sv */
// output byte predictor and scoreboard for the ecg peak rate framer
module eprf_checker
    import eprf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic [SAMPLE_BITS_DEF-1:0] sample,
    input  wire logic                       stop_request,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [7:0]                 out_byte,
    input  wire logic                       last_of_run,
    input  wire logic                       cfg_write,
    input  wire logic [IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    output int                              errors,
    output int                              pending,
    output int                              bytes_seen,
    output int                              trailers_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = SAMPLE_BITS_DEF;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    frame_byte_t frame_bytes_due[$];

    // register copies
    logic [THRESH_W-1:0] threshold;
    logic [NUM_W-1:0]    numerator;
    logic [LEN_W-1:0]    win_len;

    // window tracking
    logic [SW-1:0]      older_sample;
    logic [SW-1:0]      middle_sample;
    logic [LEN_W-1:0]   position;
    logic [LEN_W-1:0]   first_peak;
    logic [LEN_W-1:0]   second_peak;
    logic [PEAKS_W-1:0] peak_count;

    int fail_total;
    int byte_total;
    int trailer_total;

    task automatic start_window();
        position    = '0;
        peak_count  = '0;
        first_peak  = '0;
        second_peak = '0;
    endtask

    task automatic expect_byte(input logic [7:0] value, input logic last);
        frame_byte_t entry;
        entry.value = value;
        entry.last  = last;
        frame_bytes_due.push_back(entry);
    endtask

    // beats per minute from the first two peaks, saturating
    function automatic logic [7:0] beat_rate();
        logic [LEN_W-1:0] spacing;
        logic [NUM_W-1:0] quotient;
        spacing = second_peak - first_peak;
        if (peak_count < 2 || spacing == 0)
            return ZERO_BYTE;
        quotient = numerator / spacing;
        return (quotient > 16'd255) ? RATE_MAX : quotient[7:0];
    endfunction

    task automatic frame_sample(input logic [SW-1:0] s, input logic stop);
        logic [LEN_W-1:0] eff_len;
        logic [7:0]       low_byte;
        logic             closing;
        eff_len  = (win_len < MIN_WINDOW) ? MIN_WINDOW : win_len;
        low_byte = (s[7:0] == 8'd0) ? LOW_ZERO_CODE : s[7:0];
        // middle sample is judged now that its right neighbour is known
        if (position >= 2 && middle_sample >= threshold &&
            middle_sample > older_sample && middle_sample > s)
        begin
            if (peak_count == 0)
            begin
                first_peak = position - 1'b1;
                peak_count = 2'd1;
            end
            else if (peak_count == 1)
            begin
                second_peak = position - 1'b1;
                peak_count  = 2'd2;
            end
        end
        closing       = (position >= eff_len - 1'b1);
        older_sample  = middle_sample;
        middle_sample = s;
        expect_byte(SYNC_BYTE, 1'b0);
        expect_byte(8'(s >> 8), 1'b0);
        if (stop)
        begin
            expect_byte(low_byte, 1'b1);
            start_window();
        end
        else if (closing)
        begin
            expect_byte(low_byte, 1'b0);
            expect_byte(SYNC_BYTE, 1'b0);
            expect_byte(ZERO_BYTE, 1'b0);
            expect_byte(beat_rate(), 1'b1);
            trailer_total++;
            start_window();
        end
        else
        begin
            expect_byte(low_byte, 1'b1);
            position = position + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t head;
        if (!rst_n)
        begin
            threshold     = THRESH_RESET;
            numerator     = NUM_RESET;
            win_len       = LEN_RESET;
            older_sample  = '0;
            middle_sample = '0;
            start_window();
            frame_bytes_due.delete();
            fail_total    = 0;
            byte_total    = 0;
            trailer_total = 0;
        end
        else
        begin
            // output side first: a byte leaving now belongs to an earlier sample
            if (out_valid && out_ready)
            begin
                byte_total++;
                if (frame_bytes_due.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected byte transfer, expected none, got %02h last %0b",
                             $time, out_byte, last_of_run);
                end
                else
                begin
                    head = frame_bytes_due.pop_front();
                    if (out_byte !== head.value)
                    begin
                        fail_total++;
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, head.value, out_byte);
                    end
                    if (last_of_run !== head.last)
                    begin
                        fail_total++;
                        $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                                 $time, head.last, last_of_run);
                    end
                end
            end
            if (in_valid && in_ready)
                frame_sample(sample, stop_request);
            // register writes count from the next sample on
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PEAK_THRESHOLD: threshold = cfg_data[THRESH_W-1:0];
                    REG_RATE_NUMERATOR: numerator = cfg_data[NUM_W-1:0];
                    REG_WINDOW_LENGTH:  win_len   = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        errors        <= fail_total;
        pending       <= frame_bytes_due.size();
        bytes_seen    <= byte_total;
        trailers_seen <= trailer_total;
    end

endmodule

/* bench/tb_top.sv */
// testbench top for the ecg peak rate framer: stimulus, back-pressure and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eprf_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;

    // index 3 has no register behind it, so writes there must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    // watchdog limit for the whole run
    localparam int CYCLE_LIMIT  = 200000;
    // drain time for a divider started by the closing sample
    localparam int DRAIN_CYCLES = 40;
    // long output stall so the framer backs up into its input
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 88;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [SW-1:0]    sample;
    logic             stop_request;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       out_byte;
    logic             last_of_run;
    logic             cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int errors;
    int pending;
    int bytes_seen;
    int trailers_seen;

    int samples_sent;
    int settings_used;
    int cycles;

    // idle switches, redrawn per phase so some stretches run flat out
    bit sender_idles;
    bit receiver_idles;
    bit squeeze;

    ecg_peak_rate_framer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .stop_request (stop_request),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    eprf_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .stop_request  (stop_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .bytes_seen    (bytes_seen),
        .trailers_seen (trailers_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run watchdog: a hang anywhere ends here
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d bytes still expected", cycles, pending);
        $display("FAIL");
        $finish;
    end

    // sample side: optional gap, then hold valid and payload until the transfer
    // called in the step of the previous transfer, so valid either drops here
    // or goes straight on with the next payload, never both
    task automatic offer_sample(input logic [SW-1:0] value, input logic stop);
        int gap;
        gap = sender_idles ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample       <= value;
        stop_request <= stop;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    // drop valid and wait until every predicted byte has come out,
    // then wait out DRAIN_CYCLES for a divider that might still be busy
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one write per cycle, all four indexes; unused upper data bits are random
    // so the framer must mask them off
    task automatic apply_settings(input int thr, input int num, input int len);
        cfg_write <= 1'b1;
        cfg_index <= REG_PEAK_THRESHOLD;
        cfg_data  <= {2'($urandom_range(0, 3)), 14'(thr)};
        @(posedge clk);
        cfg_index <= REG_RATE_NUMERATOR;
        cfg_data  <= 16'(num);
        @(posedge clk);
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= {6'($urandom_range(0, 63)), 10'(len)};
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= 16'($urandom_range(0, 65535));
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // byte side: random stall per byte, plus one long hold while the sender
    // keeps pushing samples
    initial
    begin : receiver
        int stall;
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = receiver_idles ? $urandom_range(0, 15) : 0;
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int random_sent;
        int phase;
        int burst;
        int thr;
        int num;
        int len;
        int pick;
        int value;
        int last_value;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample         = '0;
        stop_request   = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_PEAK_THRESHOLD;
        cfg_data       = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        squeeze        = 1'b0;
        samples_sent   = 0;
        settings_used  = 0;
        random_sent    = 0;
        last_value     = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: five-sample windows at the default threshold and numerator
        apply_settings(7000, 12000, 5);
        // two peaks two apart: 6000 bpm saturates; last sample has a zero low byte
        offer_sample(14'd100, 1'b0);
        offer_sample(14'd9000, 1'b0);
        offer_sample(14'd200, 1'b0);
        offer_sample(14'd8000, 1'b0);
        offer_sample(14'h0100, 1'b0);
        // extremes; a flat top is no peak, so the rate byte is zero
        offer_sample(14'd16383, 1'b0);
        offer_sample(14'd16383, 1'b0);
        offer_sample(14'd0, 1'b0);
        offer_sample(14'd0, 1'b0);
        offer_sample(14'd0, 1'b0);
        // stop on the window's last sample wins over the trailer
        offer_sample(14'd1, 1'b0);
        offer_sample(14'd2, 1'b0);
        offer_sample(14'd3, 1'b0);
        offer_sample(14'd4, 1'b0);
        offer_sample(14'd5, 1'b1);
        settle();

        // length below the minimum acts as three; single peak at threshold zero
        apply_settings(0, 1, 0);
        offer_sample(14'd0, 1'b0);
        offer_sample(14'd1, 1'b0);
        offer_sample(14'd0, 1'b0);
        settle();

        // longest window, top threshold, top numerator; window left open
        apply_settings(16383, 65535, 1023);
        offer_sample(14'd0, 1'b0);
        offer_sample(14'd16383, 1'b0);
        offer_sample(14'd0, 1'b0);
        offer_sample(14'd16383, 1'b0);
        offer_sample(14'd0, 1'b0);
        settle();

        // shrinking the length closes the open window on the next sample,
        // numerator 200 over a spacing of two
        apply_settings(16383, 200, 3);
        offer_sample(14'd7, 1'b0);
        settle();

        // random phases: mostly short windows so trailers come often
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                thr = 0;
            else if (pick == 1)
                thr = 16383;
            else
                thr = $urandom_range(2000, 12000);
            pick = $urandom_range(0, 5);
            if (pick == 0)
                num = 65535;
            else if (pick == 1)
                num = 1;
            else if (pick < 4)
                num = $urandom_range(1, 2000);
            else
                num = $urandom_range(1, 65535);
            if ($urandom_range(0, 6) == 0)
                len = $urandom_range(0, 40);
            else
                len = $urandom_range(3, 8);
            apply_settings(thr, num, len);

            burst          = $urandom_range(8, 20);
            sender_idles   = ($urandom_range(0, 2) != 0);
            receiver_idles = ($urandom_range(0, 2) != 0);
            // third phase: flat-out sender against a receiver that goes away
            if (phase == 2)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
                squeeze       <= 1'b1;
            end

            repeat (burst)
            begin
                // mostly a low baseline with spikes above threshold, some noise
                // and some repeated values for plateaus
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    value = $urandom_range(0, 16383);
                else if (pick < 4)
                    value = $urandom_range(thr, 16383);
                else if (pick == 9)
                    value = last_value;
                else
                    value = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
                last_value = value;
                offer_sample(14'(value), ($urandom_range(0, 24) == 0));
                random_sent++;
            end
            settle();
            phase++;
        end

        $display("%0d samples over %0d register settings, %0d bytes checked",
                 samples_sent, settings_used, bytes_seen);
        $display("%0d rate trailers, random stalls on both sides and one long output hold",
                 trailers_seen);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
